// ----- rtl/bkh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary key hash package
// Shared widths, constants, codes and types of the key hash / bucket block.
// ----------------------------------------------------------------------------
package bkh_pkg;

	localparam int HASH_W   = 32;
	localparam int BYTE_W   = 8;
	localparam int BUCKET_W = 31;
	localparam int LOG2_W   = 5;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [HASH_W-1:0] HASH_INIT = 32'd1;
	localparam logic [HASH_W-1:0] STEP_INIT = 32'd4;
	localparam logic [HASH_W-1:0] STEP_INC  = 32'd3;

	// item kind codes
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_NULL = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LOG2    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECORD_COUNT = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data_byte;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [HASH_W-1:0]   hash_value;
		logic [BUCKET_W-1:0] bucket_index;
	} result_t;

	typedef struct packed {
		logic [LOG2_W-1:0] span_log2;
		logic [HASH_W-1:0] record_count;
	} cfg_t;

	// handoff from the hash core to the bucket stage
	typedef struct packed {
		logic              valid;
		logic [HASH_W-1:0] hash;
	} hash_req_t;

endpackage

// ----- rtl/bkh_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary key hash channels
// Valid/ready channels for key items in and hash results out.
// ----------------------------------------------------------------------------
interface bkh_in_if;
	import bkh_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] data_byte;
	logic              last;

	modport source (output valid, output kind, output data_byte, output last, input ready);
	modport sink   (input valid, input kind, input data_byte, input last, output ready);
endinterface

interface bkh_out_if;
	import bkh_pkg::*;

	logic                valid;
	logic                ready;
	logic [HASH_W-1:0]   hash_value;
	logic [BUCKET_W-1:0] bucket_index;

	modport source (output valid, output hash_value, output bucket_index, input ready);
	modport sink   (input valid, input hash_value, input bucket_index, output ready);
endinterface

// ----- rtl/bkh_hash_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key hash core
// Registers each key item, folds it into the running hash and step, and hands
// the finished hash of a key to the bucket stage.
// ----------------------------------------------------------------------------
module bkh_hash_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bkh_pkg::item_t      in_item,
	input  logic                req_ready,
	output bkh_pkg::hash_req_t  req
);
	import bkh_pkg::*;

	logic              valid_s1;
	item_t             item_s1;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] step_q;
	logic              valid_s2;
	logic [HASH_W-1:0] hash_s2;

	logic              take;
	logic [HASH_W-1:0] base;
	logic [HASH_W+BYTE_W-1:0] prod;
	logic [HASH_W-1:0] sum;
	logic [HASH_W-1:0] hash_nx;

	// consume a non-final item at once; a final one waits for room downstream
	assign take     = valid_s1 && (!item_s1.last || req_ready);
	assign in_ready = !valid_s1 || take;

	// one hash round
	always_comb begin
		base = {{(HASH_W-6){1'b0}}, hash_q[5:0]} + step_q;
		prod = base * item_s1.data_byte;
		sum  = prod[HASH_W-1:0] + {hash_q[HASH_W-9:0], 8'd0};
		if (item_s1.kind == KIND_NULL) begin
			hash_nx = hash_q ^ {hash_q[HASH_W-2:0], 1'b1};
		end else begin
			hash_nx = hash_q ^ sum;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			item_s1 <= in_item;
		end
	end

	// running hash and step; restart after the final item of a key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_INIT;
			step_q <= STEP_INIT;
		end else if (take) begin
			if (item_s1.last) begin
				hash_q <= HASH_INIT;
				step_q <= STEP_INIT;
			end else begin
				hash_q <= hash_nx;
				if (item_s1.kind == KIND_BYTE) begin
					step_q <= step_q + STEP_INC;
				end
			end
		end
	end

	// finished hash register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (req_ready) begin
			valid_s2 <= take && item_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready) begin
			hash_s2 <= hash_nx;
		end
	end

	assign req.valid = valid_s2;
	assign req.hash  = hash_s2;

endmodule

// ----- rtl/bkh_bucket.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucket stage
// Masks a finished hash to its linear-hash bucket and holds the result
// register of the output channel.
// ----------------------------------------------------------------------------
module bkh_bucket (
	input  logic                clk,
	input  logic                arst_n,
	input  bkh_pkg::cfg_t       cfg,
	input  bkh_pkg::hash_req_t  req,
	output logic                req_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output bkh_pkg::result_t    out_result
);
	import bkh_pkg::*;

	logic              valid_s3;
	result_t           result_s3;
	logic [HASH_W-1:0] full_mask;
	logic [HASH_W-1:0] half_mask;
	logic [HASH_W-1:0] full_hit;
	logic [HASH_W-1:0] bucket;

	assign req_ready = !valid_s3 || out_ready;

	// pick the full span if it lands below the record count, else the half span
	always_comb begin
		full_mask = ~({HASH_W{1'b1}} << cfg.span_log2);
		half_mask = full_mask >> 1;
		full_hit  = req.hash & full_mask;
		if (full_hit < cfg.record_count) begin
			bucket = full_hit;
		end else begin
			bucket = req.hash & half_mask;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (req_ready) begin
			valid_s3 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready) begin
			result_s3.hash_value   <= req.hash;
			result_s3.bucket_index <= bucket[BUCKET_W-1:0];
		end
	end

	assign out_valid  = valid_s3;
	assign out_result = result_s3;

endmodule

// ----- rtl/binary_key_hash_bucket_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary key hash with bucket selection
// Hashes a key streamed one byte or null marker per request and returns the
// final hash with its linear-hash bucket on the last request of each key.
//
//   channel   direction  payload                          handshake
//   item      in         kind, data_byte, last            valid/ready
//   result    out        hash_value, bucket_index         valid/ready
//   cfg       in         cfg_we, cfg_index, cfg_wdata     write enable only
//
// One request is taken per cycle while no final request waits on a stalled result;
// each hash round is the byte multiply-add fed back from the running hash register.
// A result passes the finished hash register and then the result register.
// Reset returns the hash to 1, the step to 4 and both registers to 0.
// Non-final requests flow on while a result is stalled; a final request
// waits while the result register holds a result that is not taken.
// ----------------------------------------------------------------------------
module binary_key_hash_bucket_top (
	input  logic                            clk,
	input  logic                            arst_n,
	bkh_in_if.sink                          item,
	bkh_out_if.source                       result,
	input  logic                            cfg_we,
	input  logic [bkh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bkh_pkg::CFG_W-1:0]       cfg_wdata
);
	import bkh_pkg::*;

	cfg_t      cfg_q;
	item_t     in_item;
	hash_req_t req;
	logic      req_ready;
	result_t   out_result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.span_log2    <= '0;
			cfg_q.record_count <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SPAN_LOG2:    cfg_q.span_log2    <= cfg_wdata[LOG2_W-1:0];
				CFG_RECORD_COUNT: cfg_q.record_count <= cfg_wdata[HASH_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_item.kind      = item.kind;
	assign in_item.data_byte = item.data_byte;
	assign in_item.last      = item.last;

	bkh_hash_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_item   (in_item),
		.req_ready (req_ready),
		.req       (req)
	);

	bkh_bucket u_bucket (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.req        (req),
		.req_ready  (req_ready),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_result (out_result)
	);

	assign result.hash_value   = out_result.hash_value;
	assign result.bucket_index = out_result.bucket_index;

	// the bucket is always a masked copy of the hash
	a_bucket_subset: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.bucket_index & ~result.hash_value[BUCKET_W-1:0]) == '0)
		else $error("bucket index has bits outside the hash");

	// a finished hash held back by the result register is kept intact
	a_hash_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && !req_ready |=> req.valid && $stable(req.hash))
		else $error("stalled hash lost or changed");

	// a stalled result blocks the hash register from taking a new one
	a_stall_chain: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready && req.valid |-> !req_ready)
		else $error("hash handed over while result stalled");

endmodule

// ----- bench/tb_binary_key_hash_bucket_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key hash and bucket testbench
// Streams keys of data bytes and null markers into the hash block across
// several bucket settings. A local copy of the hash and bucket arithmetic
// predicts each result. Every result is checked in order as it leaves,
// under random sender gaps, random result stalls and one long hold.
// ----------------------------------------------------------------------------
module tb_binary_key_hash_bucket_top;
	import bkh_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 200;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 8;
	localparam int STALL_LIMIT  = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	bkh_in_if  item_if ();
	bkh_out_if result_if ();

	binary_key_hash_bucket_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// requests waiting to be sent and results still owed
	item_t   pending_items[$];
	result_t expected_results[$];
	item_t   next_item;

	// mirror of the block state and registers
	logic [HASH_W-1:0] model_hash;
	logic [HASH_W-1:0] model_step;
	logic [LOG2_W-1:0] cfg_span;
	logic [HASH_W-1:0] cfg_records;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int hold_reqs;
	int holds_done;
	int queued_count;
	int accepted_count;
	int keys_sent;
	int results_seen;
	int error_count;
	int stall_cycles;
	int settings_used;

	always #HALF_PERIOD clk = ~clk;

	function automatic logic [BUCKET_W-1:0] bucket_pick(input logic [HASH_W-1:0] h);
		logic [HASH_W-1:0] full;
		logic [HASH_W-1:0] half;
		full = (32'd1 << cfg_span) - 32'd1;
		half = (cfg_span == 0) ? 32'd0 : (32'd1 << (cfg_span - 1)) - 32'd1;
		if ((h & full) < cfg_records)
			return BUCKET_W'(h & full);
		return BUCKET_W'(h & half);
	endfunction

	// fold one request into the running hash; true when a result is due
	function automatic bit hash_absorb(input item_t it, output result_t res);
		logic [HASH_W-1:0] h;
		h = model_hash;
		res = '0;
		if (it.kind == KIND_NULL) begin
			h = h ^ ((h << 1) | 32'd1);
		end else begin
			h = h ^ (((h & 32'd63) + model_step) * {24'd0, it.data_byte} + (h << 8));
			model_step = model_step + STEP_INC;
		end
		model_hash = h;
		if (!it.last)
			return 1'b0;
		res.hash_value = h;
		res.bucket_index = bucket_pick(h);
		model_hash = HASH_INIT;
		model_step = STEP_INIT;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
			input logic [HASH_W-1:0] want);
		$display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	task automatic push_item(input logic kind, input logic [BYTE_W-1:0] b, input logic last);
		item_t it;
		it.kind = kind;
		it.data_byte = b;
		it.last = last;
		pending_items.push_back(it);
		queued_count++;
		if (last)
			keys_sent++;
	endtask

	// queue one whole key of random bytes and null markers
	task automatic queue_key(input int len, input int null_pct);
		for (int i = 0; i < len; i++) begin
			push_item(($urandom_range(99) < null_pct) ? KIND_NULL : KIND_BYTE,
				BYTE_W'($urandom), i == len - 1);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SPAN_LOG2)
			cfg_span = value[LOG2_W-1:0];
		else
			cfg_records = value;
	endtask

	// upper bits of the span write are junk the block must drop
	task automatic apply_setting(input logic [LOG2_W-1:0] span, input logic [CFG_W-1:0] recs);
		write_reg(CFG_SPAN_LOG2, {(CFG_W-LOG2_W)'($urandom), span});
		write_reg(CFG_RECORD_COUNT, recs);
		settings_used++;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
			default: begin send_idle_pct = 15; recv_stall_pct = 15; end
		endcase
	endtask

	// hold until every queued request is taken and every result is back
	task automatic wait_drain();
		while (accepted_count != queued_count)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// request driver: hold a request until taken, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_if.valid <= 1'b0;
		end else if (!item_if.valid || item_if.ready) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = pending_items.pop_front();
				item_if.valid <= 1'b1;
				item_if.kind <= next_item.kind;
				item_if.data_byte <= next_item.data_byte;
				item_if.last <= next_item.last;
			end else begin
				item_if.valid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls, plus a long hold on demand
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			hold_left <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			result_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_reqs != holds_done) begin
			result_if.ready <= 1'b0;
			hold_left <= LONG_HOLD;
			holds_done <= holds_done + 1;
		end else begin
			result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// predict on each accepted request
	always @(posedge clk) begin
		result_t res;
		if (arst_n && item_if.valid && item_if.ready) begin
			if (hash_absorb({item_if.kind, item_if.data_byte, item_if.last}, res))
				expected_results.push_back(res);
			accepted_count++;
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result hash", result_if.hash_value, '0);
			end else begin
				want = expected_results.pop_front();
				if (result_if.hash_value !== want.hash_value)
					report_mismatch("hash_value", result_if.hash_value, want.hash_value);
				if (result_if.bucket_index !== want.bucket_index)
					report_mismatch("bucket_index", {1'b0, result_if.bucket_index},
						{1'b0, want.bucket_index});
			end
		end
	end

	// watchdog: give up after a long run of cycles with no handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[%0t] Timeout: no handshake for %0d cycles, %0d results owed",
					$time, stall_cycles, expected_results.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		logic [LOG2_W-1:0] spans[PHASES];
		logic [CFG_W-1:0]  recs[PHASES];
		int target;

		item_if.valid = 1'b0;
		item_if.kind = KIND_BYTE;
		item_if.data_byte = '0;
		item_if.last = 1'b0;
		result_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SPAN_LOG2;
		cfg_wdata = '0;
		model_hash = HASH_INIT;
		model_step = STEP_INIT;
		cfg_span = '0;
		cfg_records = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_reqs = 0;
		queued_count = 0;
		accepted_count = 0;
		keys_sent = 0;
		results_seen = 0;
		error_count = 0;
		stall_cycles = 0;
		settings_used = 0;

		// spans and record counts, extremes first
		spans = '{5'd31, 5'd31, 5'd0, 5'd1, 5'd5, 5'd12, 5'd20, 5'd0};
		recs  = '{32'h8000_0000, 32'd0, 32'd1, 32'd1, 32'd20, 32'd3000, 32'd0, 32'd0};
		spans[PHASES-1] = LOG2_W'($urandom_range(2, 30));
		recs[PHASES-1] = $urandom_range(1, 32'd1 << spans[PHASES-1]);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed keys under the reset settings: span of one, no records
		push_item(KIND_BYTE, 8'h00, 1'b1);
		push_item(KIND_BYTE, 8'hFF, 1'b1);
		push_item(KIND_NULL, 8'hA5, 1'b1);
		push_item(KIND_NULL, 8'hFF, 1'b0);
		push_item(KIND_NULL, 8'h00, 1'b0);
		push_item(KIND_BYTE, 8'h80, 1'b1);
		push_item(KIND_BYTE, 8'h01, 1'b0);
		push_item(KIND_NULL, 8'h5A, 1'b0);
		push_item(KIND_BYTE, 8'h7F, 1'b1);
		for (int i = 0; i < 12; i++)
			push_item(KIND_BYTE, 8'hFF, i == 11);
		push_item(KIND_BYTE, 8'h55, 1'b0);
		push_item(KIND_BYTE, 8'hAA, 1'b1);
		wait_drain();

		// random keys, one register setting and one idling pattern per phase
		for (int p = 0; p < PHASES; p++) begin
			apply_setting(spans[p], recs[p]);
			set_idling(p % 4);
			target = queued_count + PHASE_ITEMS;
			if (p == 5) begin
				// short keys behind a long result hold fill the block
				@(posedge clk);
				hold_reqs <= hold_reqs + 1;
				while (queued_count < target)
					queue_key($urandom_range(1, 2), 20);
			end else begin
				while (queued_count < target)
					queue_key(($urandom_range(9) == 0) ? $urandom_range(13, 40) :
						$urandom_range(1, 12), 10);
			end
			wait_drain();
		end

		$display("Ran %0d keys (%0d requests, %0d results) over %0d bucket settings,",
			keys_sent, accepted_count, results_seen, settings_used);
		$display("with sender gaps, result stalls and a %0d-cycle result hold.", LONG_HOLD);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
